[rtl/iks_pkg.sv]
// shared types and constants for the introsort key sorter
// no dependencies; used by iks_sort_core and introsort_key_sorter
`default_nettype none

package iks_pkg;

   localparam int MAX_KEYS_DEF = 64;
   localparam int KEY_BITS_DEF = 32;
   localparam int IN_KEY_BITS  = 32;
   localparam int OUT_KEY_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // word index of the compare-mode register
   localparam logic CSR_SIGNED_KEYS = 1'b0;

   typedef struct packed {
      logic                   valid;
      logic [IN_KEY_BITS-1:0] key;
      logic                   last;
   } load_req_type;

endpackage

`default_nettype wire

[rtl/iks_sort_core.sv]
// key memory and sort sequencer: load, in-place insertion sort, read-out
// depends on iks_pkg
`default_nettype none

module iks_sort_core #(
   parameter int MAX_KEYS = iks_pkg::MAX_KEYS_DEF,
   parameter int KEY_BITS = iks_pkg::KEY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire iks_pkg::load_req_type             load,
   input  wire logic                              mode_signed,
   output logic                                   busy,
   output logic                                   out_valid,
   output logic [iks_pkg::OUT_KEY_BITS-1:0]       out_key,
   output logic                                   out_last
);

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEYS);
   localparam logic [KEY_BITS-1:0] SIGN_MASK = {1'b1, {(KEY_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_HOLD, ST_CMP, ST_PLACE, ST_OUT, ST_DRAIN
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        i_ff;
   logic [AW-1:0]        j_ff;
   logic [KEY_BITS-1:0]  x_ff;
   logic                 signed_ff;
   logic                 pend_ff;
   logic                 last_pend_ff;
   logic [KEY_BITS-1:0]  rdata_ff;

   logic [KEY_BITS-1:0]  key_mem [MAX_KEYS];

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [KEY_BITS-1:0]  mem_wdata;
   logic [AW-1:0]        mem_raddr;

   logic [KEY_BITS+iks_pkg::IN_KEY_BITS-1:0]  key_wide;
   logic [KEY_BITS+iks_pkg::OUT_KEY_BITS-1:0] out_wide;
   logic [KEY_BITS-1:0]  key_ext;
   logic [KEY_BITS-1:0]  flip;
   logic                 greater;
   logic                 has_room;
   logic                 out_done;

   // zero-extend or truncate the raw key to the stored width
   assign key_wide = {{KEY_BITS{1'b0}}, load.key};
   assign key_ext  = key_wide[KEY_BITS-1:0];
   assign out_wide = {{iks_pkg::OUT_KEY_BITS{1'b0}}, rdata_ff};

   // signed order is unsigned order with the sign bit inverted
   assign flip     = signed_ff ? SIGN_MASK : '0;
   assign greater  = (rdata_ff ^ flip) > (x_ff ^ flip);
   assign has_room = count_ff < FULL_COUNT;
   assign out_done = CW'(i_ff + 1'b1) == count_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (load.valid && has_room) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[AW-1:0];
               mem_wdata = key_ext;
            end
         end
         ST_FETCH: mem_raddr = i_ff[AW-1:0];
         ST_HOLD:  mem_raddr = AW'(j_ff - 1'b1);
         ST_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = greater ? rdata_ff : x_ff;
            // look-ahead read of the next lower neighbor
            mem_raddr = AW'(j_ff - 2'd2);
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = x_ff;
         end
         ST_OUT:   mem_raddr = i_ff[AW-1:0];
         default:  mem_raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= key_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         i_ff         <= '0;
         pend_ff      <= 1'b0;
         last_pend_ff <= 1'b0;
         signed_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (load.valid) begin
                  if (has_room) begin
                     count_ff <= CW'(count_ff + 1'b1);
                  end
                  if (load.last) begin
                     signed_ff <= mode_signed;
                     i_ff      <= CW'(1);
                     state_ff  <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               if (i_ff == count_ff) begin
                  i_ff     <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  j_ff     <= i_ff[AW-1:0];
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               x_ff     <= rdata_ff;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (greater) begin
                  j_ff <= AW'(j_ff - 1'b1);
                  if (j_ff == AW'(1)) begin
                     state_ff <= ST_PLACE;
                  end
               end else begin
                  i_ff     <= CW'(i_ff + 1'b1);
                  state_ff <= ST_FETCH;
               end
            end
            ST_PLACE: begin
               i_ff     <= CW'(i_ff + 1'b1);
               state_ff <= ST_FETCH;
            end
            ST_OUT: begin
               pend_ff      <= 1'b1;
               last_pend_ff <= out_done;
               i_ff         <= CW'(i_ff + 1'b1);
               if (out_done) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               pend_ff      <= 1'b0;
               last_pend_ff <= 1'b0;
               count_ff     <= '0;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign out_valid = pend_ff;
   assign out_key   = out_wide[iks_pkg::OUT_KEY_BITS-1:0];
   assign out_last  = last_pend_ff;

endmodule

`default_nettype wire

[rtl/introsort_key_sorter.sv]
// top level of the key sorter: request and result ports, compare-mode register
// depends on iks_pkg and iks_sort_core
`default_nettype none

// Keys are taken one per cycle while busy is low (start high). The request
// with req_last_in set raises busy and starts an in-place insertion sort in
// the key memory, with at most one read and one write per cycle; each key
// moves down past the larger keys below it. Then the results follow on
// consecutive cycles, one per key and rsp_valid pulse, with rsp_last_out on
// the final one; the receiver cannot stall and must take each result in its
// cycle. busy drops in the cycle after the last result. Keys beyond MAX_KEYS
// in one set are dropped. The compare mode (signed_keys at byte address 0)
// is sampled on the last request of a set.
module introsort_key_sorter #(
   parameter int MAX_KEYS = iks_pkg::MAX_KEYS_DEF,
   parameter int KEY_BITS = iks_pkg::KEY_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [iks_pkg::IN_KEY_BITS-1:0]     req_key,
   input  wire logic                                req_last_in,
   output logic                                     rsp_valid,
   output logic [iks_pkg::OUT_KEY_BITS-1:0]         rsp_sorted_key,
   output logic                                     rsp_last_out,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [iks_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [iks_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [iks_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                     pready
);

   logic                  signed_keys_ff;
   logic                  csr_write;
   logic                  csr_hit;
   iks_pkg::load_req_type load;

   assign pready    = 1'b1;
   assign csr_hit   = paddr[iks_pkg::CSR_ADDR_BITS-1] == iks_pkg::CSR_SIGNED_KEYS;
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {{(iks_pkg::CSR_DATA_BITS-1){1'b0}}, signed_keys_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_keys_ff <= 1'b0;
      end else if (csr_write) begin
         signed_keys_ff <= pwdata[0];
      end
   end

   always_comb begin
      load.valid = start && !busy;
      load.key   = req_key;
      load.last  = req_last_in;
   end

   iks_sort_core #(
      .MAX_KEYS (MAX_KEYS),
      .KEY_BITS (KEY_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .mode_signed (signed_keys_ff),
      .busy        (busy),
      .out_valid   (rsp_valid),
      .out_key     (rsp_sorted_key),
      .out_last    (rsp_last_out)
   );

endmodule

`default_nettype wire
